FILE: src/msadpcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MS ADPCM block decoder package
// Shared types, register map and coefficient tables for the decoder.
// ----------------------------------------------------------------------------
package msadpcm_pkg;

  typedef struct packed {
    logic [7:0] enc_byte;
    logic       block_start;
  } enc_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last_of_run;
    logic               header_error;
  } pcm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       hdr_wr;
    logic       emit_load;
    logic [1:0] emit_sel;
    logic       emit_last;
    logic       mul;
    logic       nib_sel;
    logic       acc_commit;
    logic       acc_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_hdr;
    logic in_data;
    logic hdr_last;
    logic stereo;
    logic out_free;
    logic sl_ge2;
  } dp_sts_t;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_NUM_CHANNELS  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SAMPLES = 2'd1;
  localparam logic [1:0] REG_BLOCK_BYTES   = 2'd2;

  localparam logic [1:0]  NUM_CHANNELS_RST  = 2'd1;
  localparam logic [15:0] BLOCK_SAMPLES_RST = 16'd500;
  localparam logic [15:0] BLOCK_BYTES_RST   = 16'd256;

  localparam logic [1:0] CHANNELS_STEREO = 2'd2;

  // Header field order after the predictor bytes.
  localparam logic [1:0] FLD_STEP  = 2'd0;
  localparam logic [1:0] FLD_LAST  = 2'd1;
  localparam logic [1:0] FLD_OLDER = 2'd2;

  localparam logic [3:0] HDR_LEN_MONO   = 4'd7;
  localparam logic [3:0] HDR_LEN_STEREO = 4'd14;
  localparam logic [7:0] PRED_IDX_MAX   = 8'd6;

  localparam logic [17:0]        STEP_FLOOR = 18'd16;
  localparam logic signed [21:0] PCM_MAX    = 22'sd32767;
  localparam logic signed [21:0] PCM_MIN    = -22'sd32768;

  function automatic logic [9:0] adapt_factor(input logic [3:0] code);
    logic [9:0] f;
    case (code)
      4'd4, 4'd12: f = 10'd307;
      4'd5, 4'd11: f = 10'd409;
      4'd6, 4'd10: f = 10'd512;
      4'd7, 4'd9:  f = 10'd614;
      4'd8:        f = 10'd768;
      default:     f = 10'd230;
    endcase
    return f;
  endfunction

  function automatic logic signed [10:0] coef_a(input logic [2:0] idx);
    logic signed [10:0] c;
    case (idx)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      3'd6:    c = 11'sd392;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [10:0] coef_b(input logic [2:0] idx);
    logic signed [10:0] c;
    case (idx)
      3'd1:    c = -11'sd256;
      3'd3:    c = 11'sd64;
      3'd5:    c = -11'sd208;
      3'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/msadpcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MS ADPCM decoder controller
// Sequences header writes, header sample output and the two-step nibble decode.
// ----------------------------------------------------------------------------
module msadpcm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  msadpcm_pkg::dp_sts_t  sts,
  output msadpcm_pkg::ctrl_cmd_t cmd
);
  import msadpcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_EMIT = 5'b00100,
    S_MUL  = 5'b01000,
    S_ACC  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       nib_r, nib_nxt;
  logic [1:0] emit_max;

  assign emit_max = sts.stereo ? 2'd3 : 2'd1;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nib_nxt   = nib_r;
    cmd       = '0;
    cmd.emit_sel = cnt_r;
    cmd.nib_sel  = nib_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          nib_nxt    = 1'b0;
          if (sts.in_hdr) begin
            state_nxt = S_HDR;
          end else if (sts.in_data) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_HDR: begin
        cmd.hdr_wr = 1'b1;
        cnt_nxt    = 2'd0;
        state_nxt  = sts.hdr_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_last = (cnt_r == emit_max);
          if (cnt_r == emit_max) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sts.out_free) begin
          cmd.acc_commit = 1'b1;
          // The first nibble is the last result unless a second sample remains.
          cmd.acc_last = nib_r | ~sts.sl_ge2;
          if (!nib_r && sts.sl_ge2) begin
            nib_nxt   = 1'b1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
      nib_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule

FILE: src/msadpcm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MS ADPCM decoder datapath
// Configuration registers, header state, predictor arithmetic and result register.
// ----------------------------------------------------------------------------
module msadpcm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  msadpcm_pkg::enc_in_t           in_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msadpcm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output msadpcm_pkg::pcm_out_t          out_data,
  input  msadpcm_pkg::ctrl_cmd_t         cmd,
  output msadpcm_pkg::dp_sts_t           sts
);
  import msadpcm_pkg::*;

  // Configuration
  logic [1:0]  num_ch_r;
  logic [15:0] bsamp_r;
  logic [15:0] bbytes_r;
  logic        cfg_wr;

  // Block state
  logic [15:0] byte_pos_r;
  logic [16:0] samples_left_r;
  logic [7:0]  hold_r;
  logic [2:0]  pidx_r  [2];
  logic        bad_r   [2];
  logic [15:0] step_r  [2];
  logic [15:0] last_r  [2];
  logic [15:0] older_r [2];

  // Current transaction
  logic [7:0] byte_r;
  logic [3:0] pos_r;

  // Multiply stage
  logic signed [26:0] prod_a_r, prod_b_r;
  logic signed [20:0] delta_r;
  logic [25:0]        nsp_r;
  logic               ch_r;

  // Result register
  logic     out_valid_r;
  pcm_out_t out_data_r;

  logic        stereo;
  logic [3:0]  hdr_len;
  logic [15:0] pos_c;
  logic [16:0] pos_inc;
  logic [15:0] next_pos;
  logic [3:0]  k;
  logic [1:0]  field;
  logic        hdr_ch;
  logic [15:0] hdr_val;
  logic [15:0] bs_m2;
  logic [16:0] sl_hdr;

  logic               mch;
  logic [3:0]         code;
  logic signed [10:0] ca, cb;

  logic signed [27:0] sum;
  logic signed [27:0] biased;
  logic signed [19:0] quot;
  logic signed [21:0] pred;
  logic [15:0]        pcm;
  logic [17:0]        ns;
  logic [15:0]        ns_st;

  logic        emit_is_last;
  logic        emit_ch;
  logic [15:0] emit_val;

  assign stereo  = (num_ch_r == CHANNELS_STEREO);
  assign hdr_len = stereo ? HDR_LEN_STEREO : HDR_LEN_MONO;

  // Byte position of the incoming byte and of the one after it.
  assign pos_c    = in_data.block_start ? 16'd0 : byte_pos_r;
  assign pos_inc  = {1'b0, pos_c} + 17'd1;
  assign next_pos = (pos_inc >= {1'b0, bbytes_r}) ? 16'd0 : pos_inc[15:0];

  assign sts.in_hdr   = (pos_c < {12'd0, hdr_len});
  assign sts.in_data  = (samples_left_r != 17'd0);
  assign sts.hdr_last = (pos_r == (hdr_len - 4'd1));
  assign sts.stereo   = stereo;
  assign sts.out_free = ~out_valid_r | out_ready;
  assign sts.sl_ge2   = (samples_left_r >= 17'd2);

  // Header byte decode: step, sample1 and sample2 fields, low byte first.
  assign k       = pos_r - (stereo ? 4'd2 : 4'd1);
  assign field   = stereo ? k[3:2] : k[2:1];
  assign hdr_ch  = stereo & k[1];
  assign hdr_val = {byte_r, hold_r};
  assign bs_m2   = bsamp_r - 16'd2;
  assign sl_hdr  = (bsamp_r < 16'd2) ? 17'd0 :
                   (stereo ? {bs_m2, 1'b0} : {1'b0, bs_m2});

  // Multiply stage operands.
  assign mch  = cmd.nib_sel & stereo;
  assign code = cmd.nib_sel ? byte_r[3:0] : byte_r[7:4];
  assign ca   = bad_r[mch] ? 11'sd0 : coef_a(pidx_r[mch]);
  assign cb   = bad_r[mch] ? 11'sd0 : coef_b(pidx_r[mch]);

  // Accumulate stage: prediction truncated toward zero, plus scaled code, clamped.
  assign sum    = 28'(prod_a_r) + 28'(prod_b_r);
  assign biased = sum + (sum[27] ? 28'sd255 : 28'sd0);
  assign quot   = biased[27:8];
  assign pred   = 22'(quot) + 22'(delta_r);
  always_comb begin
    if (pred > PCM_MAX) begin
      pcm = 16'h7FFF;
    end else if (pred < PCM_MIN) begin
      pcm = 16'h8000;
    end else begin
      pcm = pred[15:0];
    end
  end
  assign ns    = nsp_r[25:8];
  assign ns_st = (ns < STEP_FLOOR) ? STEP_FLOOR[15:0] : ns[15:0];

  // Header sample order: sample2 of each channel, then sample1 of each channel.
  assign emit_is_last = stereo ? cmd.emit_sel[1] : cmd.emit_sel[0];
  assign emit_ch      = stereo & cmd.emit_sel[0];
  assign emit_val     = emit_is_last ? last_r[emit_ch] : older_r[emit_ch];

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    case (paddr[3:2])
      REG_NUM_CHANNELS:  prdata = {30'd0, num_ch_r};
      REG_BLOCK_SAMPLES: prdata = {16'd0, bsamp_r};
      REG_BLOCK_BYTES:   prdata = {16'd0, bbytes_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r <= NUM_CHANNELS_RST;
      bsamp_r  <= BLOCK_SAMPLES_RST;
      bbytes_r <= BLOCK_BYTES_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NUM_CHANNELS:  num_ch_r <= pwdata[1:0];
        REG_BLOCK_SAMPLES: bsamp_r  <= pwdata[15:0];
        REG_BLOCK_BYTES:   bbytes_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r     <= 16'd0;
      samples_left_r <= 17'd0;
      hold_r         <= 8'd0;
      for (int c = 0; c < 2; c++) begin
        pidx_r[c]  <= 3'd0;
        bad_r[c]   <= 1'b0;
        step_r[c]  <= 16'd0;
        last_r[c]  <= 16'd0;
        older_r[c] <= 16'd0;
      end
    end else begin
      if (cmd.accept) begin
        byte_pos_r <= next_pos;
      end
      if (cmd.hdr_wr) begin
        if (pos_r == 4'd0) begin
          samples_left_r <= 17'd0;
        end
        if (pos_r < (stereo ? 4'd2 : 4'd1)) begin
          pidx_r[pos_r[0]] <= byte_r[2:0];
          bad_r[pos_r[0]]  <= (byte_r > PRED_IDX_MAX);
        end else if (!k[0]) begin
          hold_r <= byte_r;
        end else begin
          case (field)
            FLD_STEP:  step_r[hdr_ch]  <= hdr_val;
            FLD_LAST:  last_r[hdr_ch]  <= hdr_val;
            FLD_OLDER: older_r[hdr_ch] <= hdr_val;
            default: ;
          endcase
        end
        if (sts.hdr_last) begin
          samples_left_r <= sl_hdr;
        end
      end
      if (cmd.acc_commit) begin
        step_r[ch_r]  <= ns_st;
        older_r[ch_r] <= last_r[ch_r];
        last_r[ch_r]  <= pcm;
        if (!cmd.nib_sel) begin
          samples_left_r <= sts.sl_ge2 ? (samples_left_r - 17'd2) : 17'd0;
        end
      end
    end
  end

  // Transaction and multiply-stage payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_data.enc_byte;
      pos_r  <= pos_c[3:0];
    end
    if (cmd.mul) begin
      prod_a_r <= $signed(last_r[mch]) * ca;
      prod_b_r <= $signed(older_r[mch]) * cb;
      delta_r  <= $signed({1'b0, step_r[mch]}) * $signed(code);
      nsp_r    <= step_r[mch] * adapt_factor(code);
      ch_r     <= mch;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.acc_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data_r.sample       <= emit_val;
      out_data_r.channel      <= emit_ch;
      out_data_r.last_of_run  <= cmd.emit_last;
      out_data_r.header_error <= bad_r[emit_ch];
    end else if (cmd.acc_commit) begin
      out_data_r.sample       <= pcm;
      out_data_r.channel      <= ch_r;
      out_data_r.last_of_run  <= cmd.acc_last;
      out_data_r.header_error <= bad_r[ch_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/ms_adpcm_block_decoder_top.sv
`timescale 1ns / 1ps
// A header byte is accepted, then written to the header registers; the last header byte
// then sends its 2 (mono) or 4 (stereo) samples at one per cycle unless the output stalls.
// Each decoded nibble of a data byte passes the multiply stage, then accumulate and clamp.
// Throughput is one byte at a time, set by the shared multiply/accumulate datapath.
// Reset is synchronous and active low; it restores the register defaults and clears
// all block state, with no clearing pass.
// ----------------------------------------------------------------------------
// MS ADPCM block decoder top level
// Joins the controller and datapath behind valid/ready channels and an APB port.
// ----------------------------------------------------------------------------
module ms_adpcm_block_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  msadpcm_pkg::enc_in_t           in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output msadpcm_pkg::pcm_out_t          out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msadpcm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import msadpcm_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  msadpcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msadpcm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
